### sv/audio_play_position_tracker_macros.svh
// Assertion macros for the play position tracker checks.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef AUDIO_PLAY_POSITION_TRACKER_MACROS_SVH
`define AUDIO_PLAY_POSITION_TRACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("play position tracker check failed");

// Consequent must hold in the cycle after the antecedent.
`define APT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("play position tracker check failed");

`endif

### sv/aptrk_pkg.sv
// Package of the play position tracker: sizes, payload types, status codes
// and the ring index helper. No dependencies.
package aptrk_pkg;

	localparam int CHUNK_DEPTH = 8;
	localparam int IDX_W = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
	localparam int CNT_W = $clog2(CHUNK_DEPTH + 1);

	localparam int RATE_W = 20;
	localparam int FRM_W = 48;
	localparam int PROD_W = 52;
	localparam int DIVD_W = PROD_W + 16;
	localparam logic [RATE_W-1:0] USEC_PER_SEC = 20'd1000000;
	localparam logic [FRM_W-1:0] MAX48 = {FRM_W{1'b1}};

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BACKWARD = 2'd2;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic mode;
		logic [15:0] serviced_frames;
		logic [15:0] underrun_frames;
		logic [RATE_W-1:0] out_rate;
		logic [FRM_W-1:0] engine_frames;
	} item_t;

	typedef struct packed {
		logic [FRM_W-1:0] position_us;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic [31:0] serviced;
		logic [31:0] total;
		logic [RATE_W-1:0] rate;
	} chunk_t;

	// ring slot k places after head, wrapped at the queue depth
	function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] head,
			input logic [CNT_W-1:0] k);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(head) + (CNT_W+1)'(k);
		if (s >= (CNT_W+1)'(CHUNK_DEPTH)) begin
			s = s - (CNT_W+1)'(CHUNK_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

### sv/aptrk_item_if.sv
// Handshake channel interfaces for input items and result items.
// Depends on aptrk_pkg for the payload types.
interface aptrk_item_if;
	logic valid;
	logic ready;
	aptrk_pkg::item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface aptrk_result_if;
	logic valid;
	logic ready;
	aptrk_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### sv/aptrk_ram.sv
// Chunk ring storage: one write port, one read port, registered read data.
// Depends on aptrk_pkg for the entry layout and depth.
module aptrk_ram (
	input logic clk,
	input logic we,
	input logic [aptrk_pkg::IDX_W-1:0] waddr,
	input aptrk_pkg::chunk_t wdata,
	input logic re,
	input logic [aptrk_pkg::IDX_W-1:0] raddr,
	output aptrk_pkg::chunk_t rdata
);
	aptrk_pkg::chunk_t mem [aptrk_pkg::CHUNK_DEPTH];

	// write the addressed entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read: data appears in the cycle after the read enable
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### sv/aptrk_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on aptrk_pkg for the dividend and divisor widths.
module aptrk_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [aptrk_pkg::DIVD_W-1:0] dividend,
	input logic [aptrk_pkg::RATE_W-1:0] divisor,
	output logic done,
	output logic [aptrk_pkg::DIVD_W-1:0] quotient
);
	localparam int STEP_W = $clog2(aptrk_pkg::DIVD_W);

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_q;
	logic [aptrk_pkg::RATE_W-1:0] rem_q;
	logic [aptrk_pkg::RATE_W-1:0] dsr_q;
	logic [aptrk_pkg::DIVD_W-1:0] quo_q;
	logic [aptrk_pkg::RATE_W:0] trial;
	logic fits;

	assign trial = {rem_q, quo_q[aptrk_pkg::DIVD_W-1]};
	assign fits = trial >= {1'b0, dsr_q};

	// sequence the bit steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(aptrk_pkg::DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? aptrk_pkg::RATE_W'(trial - {1'b0, dsr_q}) : trial[aptrk_pkg::RATE_W-1:0];
			quo_q <= {quo_q[aptrk_pkg::DIVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

### sv/audio_play_position_tracker.sv
// Play position tracker: appends callback records into a ring of up to eight
// output chunks and maps engine frame counts to microseconds. One item is
// processed at a time. A query passes each chunk that it retires, and the
// chunk that answers it, through the 68-step restoring divider. Results wait in
// an output register while the next item is taken.
module audio_play_position_tracker (
	input logic clk,
	input logic arst_n,
	aptrk_item_if.sink item,
	aptrk_result_if.source result
);
	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_APP_CHK  = 7'b0000010,
		S_APP_PUSH = 7'b0000100,
		S_Q_CHK    = 7'b0001000,
		S_Q_MUL    = 7'b0010000,
		S_Q_DIV    = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	localparam int IW = aptrk_pkg::IDX_W;
	localparam int CW = aptrk_pkg::CNT_W;

	state_t state_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [47:0] base_off_q;
	logic [63:0] base_pos_q;
	aptrk_pkg::item_t item_q;
	logic [47:0] frames_q;
	logic [1:0] status_q;
	logic [47:0] pos_q;
	logic retire_q;
	logic [19:0] rate_q;
	logic [51:0] mult_s1;
	logic out_valid_q;
	aptrk_pkg::result_t out_q;

	logic accept;
	logic ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	aptrk_pkg::chunk_t ram_wdata, ck;
	logic div_start, div_done;
	logic [aptrk_pkg::DIVD_W-1:0] div_dividend, div_quot;

	logic [48:0] end_sum;
	logic covers;
	logic [47:0] diff;
	logic [31:0] delta;
	logic [31:0] mul_a;
	logic [51:0] prod;
	logic merge;
	logic [68:0] pos_sum;
	logic [63:0] pos_next;
	logic [52:0] fin_sum;
	logic [IW-1:0] last_slot;

	aptrk_ram u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(ck)
	);

	aptrk_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(rate_q), .done(div_done), .quotient(div_quot)
	);

	assign item.ready = (state_q == S_IDLE);
	assign accept = item.valid && item.ready;
	assign result.valid = out_valid_q;
	assign result.data = out_q;

	// chunk window test and clipped delta
	assign end_sum = {1'b0, base_off_q} + 49'(ck.total);
	assign covers = {1'b0, frames_q} <= end_sum;
	assign diff = frames_q - base_off_q;
	assign delta = (diff > 48'(ck.serviced)) ? ck.serviced : diff[31:0];
	assign mul_a = covers ? delta : ck.serviced;
	assign prod = {20'd0, mul_a} * {32'd0, aptrk_pkg::USEC_PER_SEC};
	assign merge = (ck.rate == item_q.out_rate) &&
		((ck.serviced == ck.total) || (item_q.serviced_frames == 16'd0));
	assign last_slot = aptrk_pkg::slot_add(head_q, count_q - 1'b1);

	// rounded divide for retirement, truncated divide for the answer;
	// the retired 48.16 increment wraps at 64 bits before the saturating add
	assign div_start = (state_q == S_Q_MUL);
	assign div_dividend = {mult_s1, 16'd0} +
		aptrk_pkg::DIVD_W'(retire_q ? (rate_q >> 1) : 20'd0);
	assign pos_sum = 69'(base_pos_q) + ((rate_q == '0) ? 69'd0 : 69'(div_quot[63:0]));
	assign pos_next = (pos_sum[68:64] != '0) ? {64{1'b1}} : pos_sum[63:0];
	assign fin_sum = 53'(base_pos_q[63:16]) +
		((rate_q == '0) ? 53'd0 : 53'(div_quot[aptrk_pkg::DIVD_W-1:16]));

	// memory access per state
	always_comb begin
		ram_re = 1'b0;
		ram_raddr = head_q;
		ram_we = 1'b0;
		ram_waddr = last_slot;
		ram_wdata = ck;
		case (state_q)
			S_IDLE: begin
				ram_re = accept;
				ram_raddr = (item.data.mode == aptrk_pkg::MODE_APPEND) ?
					last_slot : head_q;
			end
			S_APP_CHK: begin
				ram_we = merge;
				ram_wdata.serviced = ck.serviced + 32'(item_q.serviced_frames);
				ram_wdata.total = ck.total + 32'(item_q.serviced_frames) +
					32'(item_q.underrun_frames);
			end
			S_APP_PUSH: begin
				ram_we = 1'b1;
				ram_waddr = aptrk_pkg::slot_add(head_q, count_q);
				ram_wdata.serviced = 32'(item_q.serviced_frames);
				ram_wdata.total = 32'(item_q.serviced_frames) +
					32'(item_q.underrun_frames);
				ram_wdata.rate = item_q.out_rate;
			end
			S_Q_DIV: begin
				ram_re = div_done && retire_q;
				ram_raddr = aptrk_pkg::slot_add(head_q, CW'(1));
			end
			default: begin
			end
		endcase
	end

	// control sequence and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			base_off_q <= '0;
			base_pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result from the done state, drop a taken one
			if (state_q == S_DONE && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.data.mode == aptrk_pkg::MODE_APPEND) begin
							state_q <= (count_q != '0) ? S_APP_CHK : S_APP_PUSH;
						end else begin
							state_q <= (count_q != '0) ? S_Q_CHK : S_DONE;
						end
					end
				end
				S_APP_CHK: begin
					if (merge || count_q == CW'(aptrk_pkg::CHUNK_DEPTH)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_APP_PUSH;
					end
				end
				S_APP_PUSH: begin
					count_q <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				S_Q_CHK: begin
					if (!covers) begin
						base_off_q <= end_sum[48] ? aptrk_pkg::MAX48 : end_sum[47:0];
					end
					state_q <= S_Q_MUL;
				end
				S_Q_MUL: begin
					state_q <= S_Q_DIV;
				end
				S_Q_DIV: begin
					if (div_done) begin
						if (retire_q) begin
							base_pos_q <= pos_next;
							head_q <= aptrk_pkg::slot_add(head_q, CW'(1));
							count_q <= count_q - 1'b1;
							state_q <= (count_q == CW'(1)) ? S_DONE : S_Q_CHK;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item fields, working values and the result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q <= item.data;
					if (item.data.engine_frames < base_off_q) begin
						frames_q <= base_off_q;
					end else begin
						frames_q <= item.data.engine_frames;
					end
					if (item.data.mode == aptrk_pkg::MODE_QUERY &&
							item.data.engine_frames < base_off_q) begin
						status_q <= aptrk_pkg::ST_BACKWARD;
					end else begin
						status_q <= aptrk_pkg::ST_OK;
					end
					if (item.data.mode == aptrk_pkg::MODE_APPEND) begin
						pos_q <= '0;
					end else begin
						pos_q <= base_pos_q[63:16];
					end
				end
			end
			S_APP_CHK: begin
				if (!merge && count_q == CW'(aptrk_pkg::CHUNK_DEPTH)) begin
					status_q <= aptrk_pkg::ST_FULL;
				end
			end
			S_Q_CHK: begin
				retire_q <= !covers;
				rate_q <= ck.rate;
				mult_s1 <= prod;
			end
			S_Q_DIV: begin
				if (div_done) begin
					if (retire_q) begin
						pos_q <= pos_next[63:16];
					end else begin
						pos_q <= (fin_sum[52:48] != '0) ? aptrk_pkg::MAX48 : fin_sum[47:0];
					end
				end
			end
			S_DONE: begin
				if (!out_valid_q || result.ready) begin
					out_q.position_us <= pos_q;
					out_q.status <= status_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

### sv/aptrk_checker.sv
// Port-level checks for the play position tracker, bound to the top level.
// Depends on the assertion macros header and aptrk_pkg for the status codes.
`include "audio_play_position_tracker_macros.svh"

module aptrk_props (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input logic [47:0] position_us,
	input logic [1:0] status
);
	// hold a waiting result
	`APT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)
	// never emit an undefined status
	`APT_ASSERT_SAME(a_status_code, result_valid, status <= aptrk_pkg::ST_BACKWARD)
	// a dropped append reports no position
	`APT_ASSERT_SAME(a_full_zero, result_valid && status == aptrk_pkg::ST_FULL, position_us == 48'd0)
	// take one item at a time
	`APT_ASSERT_NEXT(a_one_item, item_valid && item_ready, !item_ready)
endmodule

bind audio_play_position_tracker aptrk_props u_aptrk_props (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.position_us(result.data.position_us),
	.status(result.data.status)
);
